// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper: mode type, character codes,
// end-of-string status codes and the hex digit decoder.
// No dependencies.
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_QUOTE   = 2'd0,
        STAT_NO_OPEN = 2'd1,
        STAT_NUL     = 2'd2
    } status_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] BS_BYTE  = 8'h08;
    localparam logic [7:0] FF_BYTE  = 8'h0C;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] CR_BYTE  = 8'h0D;
    localparam logic [7:0] TAB_BYTE = 8'h09;

    // last of the four \u digit slots
    localparam logic [1:0] HEX_LAST_SLOT = 2'd3;

    // UTF-8 range limits and lead/continuation marks
    localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF_CONT      = 8'h80;

    // {ok, value}: ok is set for 0-9, a-f, A-F
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_decode = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_decode = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_decode = {1'b1, d[3:0]};
            end else begin
                hex_decode = 5'b0_0000;
            end
        end
    endfunction

endpackage

// ===== rtl/json_string_unescape_utf8_top.sv =====
// JSON string unescaper with UTF-8 output, top level.
// Depends on jsu_pkg (mode type, character codes, hex decoder).
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+----------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata: in_byte
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: out_byte, tuser: byte_valid,
//          |     |                              | status; tlast: last
//
// An input word lands in the input register and is decoded there combinationally; its
// results (none, one, or up to three for a \u escape) are loaded into a three-slot
// result buffer when it is free. Throughput is one word per cycle while m_axis takes
// data; a word that makes several results holds the decoder until the buffer drains.
// Reset clears the mode, the hex state, the input valid flag and the buffer count.
// Stalls on m_axis back up through the buffer and input register to s_axis_tready.
module json_string_unescape_utf8_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic       m_axis_tlast    // last
);

    // ---------------- input register ----------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       item_go;      // decoder consumes the input word this cycle

    // ---------------- decoder state ----------------
    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_count_reg, hex_count_next;
    logic [15:0]    code_reg, code_next;
    logic           stopped_reg, stopped_next;

    // ---------------- result buffer ----------------
    logic [7:0]       slot_reg [3];
    logic [7:0]       slot_next [3];
    logic [1:0]       cnt_reg, cnt_next;
    logic             last_reg, last_next;
    jsu_pkg::status_t status_reg, status_next;

    // decoder outputs for the word in the input register
    logic [1:0]       res_cnt;
    logic [7:0]       res_byte [3];
    logic             res_last;
    jsu_pkg::status_t res_status;

    logic [4:0]  hex_dec;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code_upd;
    logic        pop;
    logic        buf_free;

    // buffer can take a new burst when empty or when its last entry leaves now
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign item_go  = in_valid_reg && buf_free;

    assign s_axis_tready = !in_valid_reg || item_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (item_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // hex digit of the current word; once a non-hex byte is seen the value freezes
    assign hex_dec  = jsu_pkg::hex_decode(in_byte_reg);
    assign hex_ok   = hex_dec[4];
    assign hex_val  = hex_dec[3:0];
    assign code_upd = (stopped_reg || !hex_ok) ? code_reg : {code_reg[11:0], hex_val};

    // ---------------- decode ----------------
    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        code_next      = code_reg;
        stopped_next   = stopped_reg;
        res_cnt        = 2'd0;
        res_byte[0]    = 8'h00;
        res_byte[1]    = 8'h00;
        res_byte[2]    = 8'h00;
        res_last       = 1'b0;
        res_status     = jsu_pkg::STAT_QUOTE;

        priority if (mode_reg == jsu_pkg::MODE_IDLE)
        begin
            if (in_byte_reg == jsu_pkg::CH_QUOTE)
            begin
                mode_next      = jsu_pkg::MODE_TEXT;
                hex_count_next = 2'd0;
                code_next      = 16'h0000;
                stopped_next   = 1'b0;
            end
            else
            begin
                res_cnt    = 2'd1;
                res_last   = 1'b1;
                res_status = jsu_pkg::STAT_NO_OPEN;
            end
        end
        else if (in_byte_reg == jsu_pkg::CH_NUL)
        begin
            // NUL ends the string anywhere, dropping a partial escape
            mode_next      = jsu_pkg::MODE_IDLE;
            hex_count_next = 2'd0;
            code_next      = 16'h0000;
            stopped_next   = 1'b0;
            res_cnt        = 2'd1;
            res_last       = 1'b1;
            res_status     = jsu_pkg::STAT_NUL;
        end
        else
        begin
            unique case (mode_reg)
                jsu_pkg::MODE_TEXT:
                begin
                    if (in_byte_reg == jsu_pkg::CH_QUOTE)
                    begin
                        mode_next  = jsu_pkg::MODE_IDLE;
                        res_cnt    = 2'd1;
                        res_last   = 1'b1;
                        res_status = jsu_pkg::STAT_QUOTE;
                    end
                    else if (in_byte_reg == jsu_pkg::CH_BSL)
                    begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end
                    else
                    begin
                        res_cnt     = 2'd1;
                        res_byte[0] = in_byte_reg;
                    end
                end
                jsu_pkg::MODE_ESC:
                begin
                    mode_next = jsu_pkg::MODE_TEXT;
                    unique case (in_byte_reg)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = in_byte_reg;
                        end
                        jsu_pkg::CH_B:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = jsu_pkg::BS_BYTE;
                        end
                        jsu_pkg::CH_F:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = jsu_pkg::FF_BYTE;
                        end
                        jsu_pkg::CH_N:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = jsu_pkg::LF_BYTE;
                        end
                        jsu_pkg::CH_R:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = jsu_pkg::CR_BYTE;
                        end
                        jsu_pkg::CH_T:
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = jsu_pkg::TAB_BYTE;
                        end
                        jsu_pkg::CH_U:
                        begin
                            mode_next      = jsu_pkg::MODE_HEX;
                            hex_count_next = 2'd0;
                            code_next      = 16'h0000;
                            stopped_next   = 1'b0;
                        end
                        default:
                        begin
                            // unknown escape character is dropped
                            mode_next = jsu_pkg::MODE_TEXT;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX:
                begin
                    // a quote here counts as a non-hex byte, not as the end
                    stopped_next = stopped_reg | ~hex_ok;
                    code_next    = code_upd;
                    if (hex_count_reg != jsu_pkg::HEX_LAST_SLOT)
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        mode_next      = jsu_pkg::MODE_TEXT;
                        hex_count_next = 2'd0;
                        code_next      = 16'h0000;
                        stopped_next   = 1'b0;
                        priority if (code_upd < jsu_pkg::UTF_ONE_LIMIT)
                        begin
                            res_cnt     = 2'd1;
                            res_byte[0] = code_upd[7:0];
                        end
                        else if (code_upd < jsu_pkg::UTF_TWO_LIMIT)
                        begin
                            res_cnt     = 2'd2;
                            res_byte[0] = jsu_pkg::UTF_LEAD2 | {3'b000, code_upd[10:6]};
                            res_byte[1] = jsu_pkg::UTF_CONT | {2'b00, code_upd[5:0]};
                        end
                        else
                        begin
                            res_cnt     = 2'd3;
                            res_byte[0] = jsu_pkg::UTF_LEAD3 | {4'h0, code_upd[15:12]};
                            res_byte[1] = jsu_pkg::UTF_CONT | {2'b00, code_upd[11:6]};
                            res_byte[2] = jsu_pkg::UTF_CONT | {2'b00, code_upd[5:0]};
                        end
                    end
                end
                jsu_pkg::MODE_IDLE:
                begin
                    // taken by the branch above
                    mode_next = jsu_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= jsu_pkg::MODE_IDLE;
            hex_count_reg <= 2'd0;
            code_reg      <= 16'h0000;
            stopped_reg   <= 1'b0;
        end
        else if (item_go)
        begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            code_reg      <= code_next;
            stopped_reg   <= stopped_next;
        end
    end

    // ---------------- result buffer ----------------
    // A new burst only loads when the buffer is empty or emptying, so loading
    // takes priority over the shift.
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        if (item_go && (res_cnt != 2'd0))
        begin
            slot_next[0] = res_byte[0];
            slot_next[1] = res_byte[1];
            slot_next[2] = res_byte[2];
            cnt_next     = res_cnt;
            last_next    = res_last;
            status_next  = res_status;
        end
        else if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            last_reg   <= 1'b0;
            status_reg <= jsu_pkg::STAT_QUOTE;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = slot_reg[0];
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = {status_reg, ~last_reg};

    // ---------------- assertions ----------------
    // an end marker is always a burst of its own and carries no byte
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (cnt_reg == 2'd1) && (m_axis_tdata == 8'h00))
        else $error("end marker shares the buffer or carries data");

    // data words report status zero
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (status_reg == jsu_pkg::STAT_QUOTE))
        else $error("data word with nonzero status");

    // the hex slot counter only runs inside a \u escape
    a_hex_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (hex_count_reg != 2'd0) |-> (mode_reg == jsu_pkg::MODE_HEX))
        else $error("hex slot count outside hex mode");

    // a burst of three bytes only follows the last \u slot
    a_three_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (item_go && (res_cnt == 2'd3)) |=> (mode_reg == jsu_pkg::MODE_TEXT)
            && (hex_count_reg == 2'd0))
        else $error("three-byte burst without completing a \\u escape");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for json_string_unescape_utf8_top: streams quoted JSON string bytes
// in and checks every decoded word against a cycle-free predictor.
// Depends on jsu_pkg (mode type, status codes, character and UTF-8 constants).
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_TAIL   = 30;    // last words sent with no idling
    localparam int ITEMS       = 160;   // at least this many input words, directed ones included

    // one expected word on m_axis
    typedef struct packed {
        logic [7:0] chr;
        logic       is_byte;
        logic [1:0] stat;
        logic       is_last;
    } decoded_t;

    // Predicts the decoded words and keeps them in arrival order.
    class unescape_board;
        decoded_t        want_q[$];
        int              errors;
        jsu_pkg::mode_t  mode_r;
        logic [1:0]      slot_cnt;
        logic [15:0]     code_acc;
        bit              hex_dead;

        function new();
            mode_r = jsu_pkg::MODE_IDLE;
            wipe_hex();
            errors = 0;
        endfunction

        function void wipe_hex();
            slot_cnt = '0;
            code_acc = '0;
            hex_dead = 1'b0;
        endfunction

        function void push_chr(logic [7:0] c);
            want_q.push_back('{chr: c, is_byte: 1'b1, stat: jsu_pkg::STAT_QUOTE,
                               is_last: 1'b0});
        endfunction

        function void push_end(jsu_pkg::status_t s);
            want_q.push_back('{chr: 8'h00, is_byte: 1'b0, stat: s, is_last: 1'b1});
        endfunction

        // -1 for anything that is not 0-9, a-f, A-F
        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        // one accepted input word
        function void note_byte(logic [7:0] c);
            int          d;
            logic [15:0] cp;
            logic [3:0]  nib;
            if (mode_r == jsu_pkg::MODE_IDLE) begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    mode_r = jsu_pkg::MODE_TEXT;
                    wipe_hex();
                end
                else
                    push_end(jsu_pkg::STAT_NO_OPEN);
                return;
            end
            // NUL ends the string from any inner mode, partial escapes dropped
            if (c == jsu_pkg::CH_NUL) begin
                mode_r = jsu_pkg::MODE_IDLE;
                wipe_hex();
                push_end(jsu_pkg::STAT_NUL);
                return;
            end
            case (mode_r)
                jsu_pkg::MODE_TEXT:
                begin
                    if (c == jsu_pkg::CH_QUOTE) begin
                        mode_r = jsu_pkg::MODE_IDLE;
                        push_end(jsu_pkg::STAT_QUOTE);
                    end
                    else if (c == jsu_pkg::CH_BSL)
                        mode_r = jsu_pkg::MODE_ESC;
                    else
                        push_chr(c);
                end
                jsu_pkg::MODE_ESC:
                begin
                    mode_r = jsu_pkg::MODE_TEXT;
                    case (c)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: push_chr(c);
                        jsu_pkg::CH_B: push_chr(jsu_pkg::BS_BYTE);
                        jsu_pkg::CH_F: push_chr(jsu_pkg::FF_BYTE);
                        jsu_pkg::CH_N: push_chr(jsu_pkg::LF_BYTE);
                        jsu_pkg::CH_R: push_chr(jsu_pkg::CR_BYTE);
                        jsu_pkg::CH_T: push_chr(jsu_pkg::TAB_BYTE);
                        jsu_pkg::CH_U:
                        begin
                            mode_r = jsu_pkg::MODE_HEX;
                            wipe_hex();
                        end
                        default: ;  // unknown escape is dropped
                    endcase
                end
                default:
                begin
                    // \u slot: value built up to the first non-hex byte
                    d = nibble_of(c);
                    if (!hex_dead) begin
                        if (d < 0)
                            hex_dead = 1'b1;
                        else begin
                            nib = d[3:0];
                            code_acc = {code_acc[11:0], nib};
                        end
                    end
                    if (slot_cnt != jsu_pkg::HEX_LAST_SLOT) begin
                        slot_cnt++;
                        return;
                    end
                    cp = code_acc;
                    mode_r = jsu_pkg::MODE_TEXT;
                    wipe_hex();
                    if (cp < jsu_pkg::UTF_ONE_LIMIT)
                        push_chr(cp[7:0]);
                    else if (cp < jsu_pkg::UTF_TWO_LIMIT) begin
                        push_chr(jsu_pkg::UTF_LEAD2 | {3'b000, cp[10:6]});
                        push_chr(jsu_pkg::UTF_CONT | {2'b00, cp[5:0]});
                    end
                    else begin
                        push_chr(jsu_pkg::UTF_LEAD3 | {4'b0000, cp[15:12]});
                        push_chr(jsu_pkg::UTF_CONT | {2'b00, cp[11:6]});
                        push_chr(jsu_pkg::UTF_CONT | {2'b00, cp[5:0]});
                    end
                end
            endcase
        endfunction

        // one accepted output word, compared with the oldest expectation
        function void check_result(logic [7:0] data, logic [2:0] user, logic tl);
            decoded_t w;
            if (want_q.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b tlast %b", data, user, tl);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (data !== w.chr) begin
                $error("out_byte: expected %h, got %h", w.chr, data);
                errors++;
            end
            if (user[0] !== w.is_byte) begin
                $error("byte_valid: expected %b, got %b", w.is_byte, user[0]);
                errors++;
            end
            if (user[2:1] !== w.stat) begin
                $error("status: expected %0d, got %0d", w.stat, user[2:1]);
                errors++;
            end
            if (tl !== w.is_last) begin
                $error("last: expected %b, got %b", w.is_last, tl);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [2:0] m_axis_tuser;            // [0] byte_valid, [2:1] status
    logic       m_axis_tlast;            // last

    unescape_board board = new();
    logic [7:0]    stream_q[$];          // raw string bytes to send, in order
    bit            quiet = 1'b0;         // set for the tail: no idling on either side
    int            cycles = 0;

    json_string_unescape_utf8_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both handshakes are sampled at the edge; the input word is noted first
    // so its expectation exists before any later result needs it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // ASCII hex digit, case picked at random for letters
    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
    endfunction

    function automatic bit is_short_escape(logic [7:0] c);
        return c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL || c == jsu_pkg::CH_SLASH ||
               c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
               c == jsu_pkg::CH_R || c == jsu_pkg::CH_T;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
        return c;
    endfunction

    // \u escape whose value lands in one of the three UTF-8 length classes;
    // a damaged one may swap digit slots for non-hex bytes
    task automatic add_u_escape(bit damaged);
        logic [15:0] cp;
        logic [7:0]  c;
        int          k;
        case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(0, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        stream_q.push_back(jsu_pkg::CH_BSL);
        stream_q.push_back(jsu_pkg::CH_U);
        for (k = 3; k >= 0; k--) begin
            if (damaged && $urandom_range(0, 2) == 0) begin
                do
                    c = 8'($urandom_range(1, 255));
                while (board.nibble_of(c) >= 0);
                stream_q.push_back(c);
            end
            else
                stream_q.push_back(hex_char(cp[4*k +: 4]));
        end
    endtask

    // Mostly well-formed strings with random content; some broken strings
    // cut off by NUL and some stray bytes while no string is open.
    task automatic build_random(int goal);
        int         pieces;
        int         k;
        logic [7:0] c;
        while (stream_q.size() < goal) begin
            case ($urandom_range(0, 19))
                0:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == jsu_pkg::CH_QUOTE);
                    stream_q.push_back(c);
                end
                1, 2:
                begin
                    stream_q.push_back(jsu_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 3)) stream_q.push_back(plain_byte());
                    stream_q.push_back(jsu_pkg::CH_BSL);
                    if ($urandom_range(0, 1)) begin
                        stream_q.push_back(jsu_pkg::CH_U);
                        repeat ($urandom_range(0, 3))
                            stream_q.push_back(hex_char(4'($urandom_range(0, 15))));
                    end
                    stream_q.push_back(jsu_pkg::CH_NUL);
                end
                default:
                begin
                    stream_q.push_back(jsu_pkg::CH_QUOTE);
                    pieces = $urandom_range(0, 7);
                    for (k = 0; k < pieces; k++) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: stream_q.push_back(plain_byte());
                            4:
                            begin
                                do
                                    c = 8'($urandom_range(0, 255));
                                while (!is_short_escape(c));
                                stream_q.push_back(jsu_pkg::CH_BSL);
                                stream_q.push_back(c);
                            end
                            5:
                            begin
                                do
                                    c = 8'($urandom_range(1, 255));
                                while (is_short_escape(c) || c == jsu_pkg::CH_U);
                                stream_q.push_back(jsu_pkg::CH_BSL);
                                stream_q.push_back(c);
                            end
                            6, 7, 8: add_u_escape(1'b0);
                            default: add_u_escape(1'b1);
                        endcase
                    end
                    stream_q.push_back(($urandom_range(0, 9) == 0) ?
                                       jsu_pkg::CH_NUL : jsu_pkg::CH_QUOTE);
                end
            endcase
        end
    endtask

    // Directed opening: missing open quote, top byte value, an escaped quote,
    // an unknown escape, a three-byte \u, a \u with a quote in its first slot
    // ahead of its digits, NUL inside the slots and NUL right after a backslash.
    task automatic load_directed();
        logic [7:0] seq[$];
        seq = '{"x", jsu_pkg::CH_QUOTE, 8'hFF, jsu_pkg::CH_BSL, jsu_pkg::CH_QUOTE,
                jsu_pkg::CH_BSL, "q",
                jsu_pkg::CH_BSL, jsu_pkg::CH_U, "F", "f", "f", "F",
                jsu_pkg::CH_BSL, jsu_pkg::CH_U, jsu_pkg::CH_QUOTE, "z", "1", "2",
                jsu_pkg::CH_BSL, jsu_pkg::CH_U, "a", jsu_pkg::CH_NUL,
                jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_NUL};
        foreach (seq[i]) stream_q.push_back(seq[i]);
    endtask

    // s_axis driver, with idle bursts until the calm tail
    task automatic send_stream();
        int idx;
        idx = 0;
        while (idx < stream_q.size()) begin
            if (idx >= stream_q.size() - CALM_TAIL)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stream_q[idx];
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            idx++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // m_axis back-pressure, with stall bursts until the calm tail
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        load_directed();
        build_random(ITEMS);
        @(posedge clk);
        send_stream();
        // drain, then wait so the pipeline can show any stray word
        while (board.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== json_string_unescape_utf8_top.f =====
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8_top.sv
tb/sv/tb.sv
